// File: hw/rtl/dmf_pkg.sv
// ----------------------------------------------------------------------------
// dmf_pkg
// Shared types and constants for the duplicate message filter: field widths,
// controller states and the command/status bundles between its two halves.
// ----------------------------------------------------------------------------
`default_nettype none

package dmf_pkg;

    localparam int SRC_W               = 32;
    localparam int SEQ_W               = 16;
    localparam int ENTRY_W             = SRC_W + SEQ_W;
    localparam int DEFAULT_CACHE_DEPTH = 32;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FLUSH,
        ST_RESOLVE
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_key;    // capture the incoming pair, restart the scan
        logic issue_read;  // read the store entry under the scan address
        logic commit;      // load the result register, store the pair on a miss
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic store_empty; // no entry has been written since reset
        logic last_addr;   // scan address points at the last filled entry
        logic out_free;    // result register can take a new result this cycle
    } sts_t;

endpackage

`default_nettype wire

// File: hw/rtl/dmf_datapath.sv
// ----------------------------------------------------------------------------
// dmf_datapath
// Entry store, sequential compare against the held key, round-robin fill
// pointer, fill count and the registered result stage.
// ----------------------------------------------------------------------------
`default_nettype none

module dmf_datapath #(
    parameter int CACHE_DEPTH = dmf_pkg::DEFAULT_CACHE_DEPTH
) (
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire dmf_pkg::cmd_t            cmd,
    output dmf_pkg::sts_t                 sts,
    input  wire logic [dmf_pkg::SRC_W-1:0] s_source_address,
    input  wire logic [dmf_pkg::SEQ_W-1:0] s_sequence_number,
    output logic                          m_valid,
    input  wire logic                     m_ready,
    output logic                          m_is_duplicate
);

    localparam int PTR_W = (CACHE_DEPTH > 1) ? $clog2(CACHE_DEPTH) : 1;
    localparam int CNT_W = $clog2(CACHE_DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(CACHE_DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(CACHE_DEPTH);

    logic [dmf_pkg::ENTRY_W-1:0] mem [CACHE_DEPTH];

    logic [dmf_pkg::ENTRY_W-1:0] key_reg;
    logic [dmf_pkg::ENTRY_W-1:0] rd_data_reg;
    logic                        rd_vld_reg;
    logic [PTR_W-1:0]            rd_addr_reg, rd_addr_next;
    logic                        hit_reg, hit_next;
    logic [PTR_W-1:0]            wr_ptr_reg, wr_ptr_next;
    logic [CNT_W-1:0]            fill_cnt_reg, fill_cnt_next;
    logic                        m_valid_reg, m_valid_next;
    logic                        m_dup_reg;
    logic                        store_miss;

    assign store_miss = cmd.commit && !hit_reg;

    // Store: one write port, one registered read port.
    always_ff @(posedge aclk) begin
        if (store_miss) begin
            mem[wr_ptr_reg] <= key_reg;
        end
        if (cmd.issue_read) begin
            rd_data_reg <= mem[rd_addr_reg];
        end
        if (cmd.load_key) begin
            key_reg <= {s_source_address, s_sequence_number};
        end
        if (cmd.commit) begin
            m_dup_reg <= hit_reg;
        end
    end

    always_comb begin
        rd_addr_next  = rd_addr_reg;
        hit_next      = hit_reg;
        wr_ptr_next   = wr_ptr_reg;
        fill_cnt_next = fill_cnt_reg;
        m_valid_next  = m_valid_reg;
        if (cmd.load_key) begin
            rd_addr_next = '0;
            hit_next     = 1'b0;
        end else begin
            if (cmd.issue_read) begin
                rd_addr_next = rd_addr_reg + PTR_W'(1);
            end
            if (rd_vld_reg && (rd_data_reg == key_reg)) begin
                hit_next = 1'b1;
            end
        end
        if (store_miss) begin
            wr_ptr_next = (wr_ptr_reg == LAST_SLOT) ? '0 : wr_ptr_reg + PTR_W'(1);
            if (fill_cnt_reg != FULL_CNT) begin
                fill_cnt_next = fill_cnt_reg + CNT_W'(1);
            end
        end
        if (cmd.commit) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_vld_reg   <= 1'b0;
            rd_addr_reg  <= '0;
            hit_reg      <= 1'b0;
            wr_ptr_reg   <= '0;
            fill_cnt_reg <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            rd_vld_reg   <= cmd.issue_read;
            rd_addr_reg  <= rd_addr_next;
            hit_reg      <= hit_next;
            wr_ptr_reg   <= wr_ptr_next;
            fill_cnt_reg <= fill_cnt_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    assign sts.store_empty = (fill_cnt_reg == '0);
    assign sts.last_addr   = ((CNT_W'(rd_addr_reg) + CNT_W'(1)) == fill_cnt_reg);
    assign sts.out_free    = !m_valid_reg || m_ready;

    assign m_valid        = m_valid_reg;
    assign m_is_duplicate = m_dup_reg;

    // The fill count never passes the store depth.
    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_cnt_reg <= FULL_CNT)
        else $error("fill count above store depth");

    // Until the store is full, the fill pointer sits right after the last entry.
    a_ptr_tracks_fill: assert property (@(posedge aclk) disable iff (!aresetn)
        (fill_cnt_reg != FULL_CNT) |-> (CNT_W'(wr_ptr_reg) == fill_cnt_reg))
        else $error("fill pointer out of step with fill count");

    // A result is never loaded over one that is still waiting.
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.commit |-> (!m_valid_reg || m_ready))
        else $error("result register overwritten");

    // A miss grows the store by one entry until it is full.
    a_miss_grows: assert property (@(posedge aclk) disable iff (!aresetn)
        (store_miss && (fill_cnt_reg != FULL_CNT)) |=>
            (fill_cnt_reg == $past(fill_cnt_reg) + CNT_W'(1)))
        else $error("miss did not add an entry");

endmodule

`default_nettype wire

// File: hw/rtl/dmf_ctrl.sv
// ----------------------------------------------------------------------------
// dmf_ctrl
// Controller: accepts one pair, walks the filled entries, then commits the
// verdict into the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module dmf_ctrl (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_valid,
    output logic               s_ready,
    output dmf_pkg::cmd_t      cmd,
    input  wire dmf_pkg::sts_t sts
);

    dmf_pkg::state_t state_reg, state_next;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            dmf_pkg::ST_IDLE: begin
                if (s_valid) begin
                    state_next = sts.store_empty ? dmf_pkg::ST_RESOLVE : dmf_pkg::ST_SCAN;
                end
            end
            dmf_pkg::ST_SCAN: begin
                if (sts.last_addr) begin
                    state_next = dmf_pkg::ST_FLUSH;
                end
            end
            dmf_pkg::ST_FLUSH: begin
                state_next = dmf_pkg::ST_RESOLVE;
            end
            dmf_pkg::ST_RESOLVE: begin
                if (sts.out_free) begin
                    state_next = dmf_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = dmf_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        s_ready        = 1'b0;
        cmd.load_key   = 1'b0;
        cmd.issue_read = 1'b0;
        cmd.commit     = 1'b0;
        unique case (state_reg)
            dmf_pkg::ST_IDLE: begin
                s_ready      = 1'b1;
                cmd.load_key = s_valid;
            end
            dmf_pkg::ST_SCAN: begin
                cmd.issue_read = 1'b1;
            end
            dmf_pkg::ST_FLUSH: begin
            end
            dmf_pkg::ST_RESOLVE: begin
                cmd.commit = sts.out_free;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= dmf_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/duplicate_message_filter_core.sv
// ----------------------------------------------------------------------------
// duplicate_message_filter_core
// Flags (source, sequence) pairs already seen among the last CACHE_DEPTH new
// pairs; new pairs are stored round-robin over the oldest entry.
// ----------------------------------------------------------------------------
// Usage:
// The s_ channel carries one message per transfer: a 32-bit source address
// and a 16-bit sequence number. The m_ channel returns exactly one result per
// message, in order: m_is_duplicate is 1 when the pair is already held, and
// 0 when it was new and has just been stored.
// One message is processed at a time. After a transfer is taken, the
// controller reads the N entries filled so far, one per cycle from the
// single read port of the entry store, then makes a final compare of the
// last entry read and commits the verdict into the result register; the
// next input is taken only after that commit. While the store is empty the
// scan is skipped and the verdict is committed directly.
// N grows by one per new pair until it reaches CACHE_DEPTH, so the read port
// sets the rate.
// The result sits in an output register. When the receiver stalls, the block
// still takes one more input and scans it, then holds that verdict until the
// waiting result has been taken, and takes no further input meanwhile.
// Reset clears the fill count and pointer, so the store reads as empty at
// once; no clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module duplicate_message_filter_core #(
    parameter int CACHE_DEPTH = dmf_pkg::DEFAULT_CACHE_DEPTH
) (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      s_valid,
    output logic                           s_ready,
    input  wire logic [dmf_pkg::SRC_W-1:0] s_source_address,
    input  wire logic [dmf_pkg::SEQ_W-1:0] s_sequence_number,
    output logic                           m_valid,
    input  wire logic                      m_ready,
    output logic                           m_is_duplicate
);

    // Command and status bundles between the controller and the datapath.
    dmf_pkg::cmd_t cmd;
    dmf_pkg::sts_t sts;

    // The controller sequences accept, scan, final compare and commit.
    dmf_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .cmd     (cmd),
        .sts     (sts)
    );

    // The datapath holds the entry store, the key and the result register.
    dmf_datapath #(
        .CACHE_DEPTH (CACHE_DEPTH)
    ) u_datapath (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cmd               (cmd),
        .sts               (sts),
        .s_source_address  (s_source_address),
        .s_sequence_number (s_sequence_number),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_is_duplicate    (m_is_duplicate)
    );

endmodule

`default_nettype wire
